>>> hdl/assert_macros.svh
// Assertion macros for the base-85 encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define B85_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define B85_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define B85_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define B85_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/b85_pkg.sv
// Types, constants and arithmetic helpers for the base-85 group encoder.
package b85_pkg;

  localparam int GroupChars = 5;
  localparam logic [6:0] CharOffset = 7'd33;
  localparam logic [31:0] Recip85 = 32'hC0C0C0C1;
  localparam int Recip85Shift = 38;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       group_end;
    logic       stream_end;
  } out_word_t;

  typedef struct packed {
    logic [2:0] count;
    logic       stream_end;
  } meta_t;

  typedef struct packed {
    logic [31:0] value;
    meta_t       meta;
  } grp_t;

  typedef struct packed {
    logic [GroupChars-1:0][6:0] chars;
    meta_t                      meta;
  } dig_t;

  // Exact quotient by 85 for any 32-bit value, by reciprocal multiplication.
  function automatic logic [25:0] div85(input logic [31:0] v);
    logic [63:0] p;
    p = {32'd0, v} * {32'd0, Recip85};
    return p[Recip85Shift+25:Recip85Shift];
  endfunction

  // Remainder x - 85*q, where only the low seven bits of x and q matter.
  function automatic logic [6:0] rem85(input logic [6:0] x_lo, input logic [6:0] q_lo);
    logic [13:0] p;
    p = {7'd0, q_lo} * 14'd85;
    return x_lo - p[6:0];
  endfunction

endpackage

>>> hdl/b85_digit_pipe.sv
// Pipeline that splits a 32-bit group into five base-85 character codes.
module b85_digit_pipe (
  input  logic           clk,
  input  logic           rst,
  input  logic           grp_valid,
  input  b85_pkg::grp_t  grp,
  input  logic           move,
  output logic           grp_free,
  output logic           dig_valid,
  output b85_pkg::dig_t  dig
);

  logic [5:0]            vld;
  b85_pkg::meta_t        meta [0:5];
  logic [31:0]           v0;
  logic [25:0]           q1;
  logic [19:0]           q2;
  logic [12:0]           q3;
  logic [6:0]            q4;
  logic [6:0]            lo1;
  logic [6:0]            lo2;
  logic [6:0]            lo3;
  logic [6:0]            lo4;
  logic [6:0]            d4_s2;
  logic [6:0]            d4_s3;
  logic [6:0]            d4_s4;
  logic [6:0]            d3_s3;
  logic [6:0]            d3_s4;
  logic [6:0]            d2_s4;
  logic [25:0]           q2_full;
  logic [25:0]           q3_full;
  logic [25:0]           q4_full;
  logic [4:0][6:0]       chars;

  assign grp_free  = move || !vld[0];
  assign dig_valid = vld[5];
  assign dig.chars = chars;
  assign dig.meta  = meta[5];

  always_comb begin
    q2_full = b85_pkg::div85({6'd0, q1});
    q3_full = b85_pkg::div85({12'd0, q2});
    q4_full = b85_pkg::div85({19'd0, q3});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (grp_free) begin
        vld[0] <= grp_valid;
      end
      if (move) begin
        vld[5:1] <= vld[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_free) begin
      v0      <= grp.value;
      meta[0] <= grp.meta;
    end
    if (move) begin
      q1    <= b85_pkg::div85(v0);
      lo1   <= v0[6:0];
      q2    <= q2_full[19:0];
      d4_s2 <= b85_pkg::rem85(lo1, q1[6:0]);
      lo2   <= q1[6:0];
      q3    <= q3_full[12:0];
      d3_s3 <= b85_pkg::rem85(lo2, q2[6:0]);
      d4_s3 <= d4_s2;
      lo3   <= q2[6:0];
      q4    <= q4_full[6:0];
      d2_s4 <= b85_pkg::rem85(lo3, q3[6:0]);
      d3_s4 <= d3_s3;
      d4_s4 <= d4_s3;
      lo4   <= q3[6:0];
      chars[0] <= q4 + b85_pkg::CharOffset;
      chars[1] <= b85_pkg::rem85(lo4, q4) + b85_pkg::CharOffset;
      chars[2] <= d2_s4 + b85_pkg::CharOffset;
      chars[3] <= d3_s4 + b85_pkg::CharOffset;
      chars[4] <= d4_s4 + b85_pkg::CharOffset;
      meta[1] <= meta[0];
      meta[2] <= meta[1];
      meta[3] <= meta[2];
      meta[4] <= meta[3];
      meta[5] <= meta[4];
    end
  end

endmodule

>>> hdl/base85_group_encoder_top.sv
// Top level of the base-85 group encoder: byte collection and character output.
// A group that the accepted byte completes or ends passes the pipeline's input register,
// its quotient and character stages, the held character set and the output register.
// Throughput: one byte per cycle in, one character per cycle out, while byte_stall and
// char_stall are low; a full group of four bytes gives five characters.
// Reset clears the held bytes, the pipeline valid bits and the output valid.
`include "assert_macros.svh"

module base85_group_encoder_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  b85_pkg::in_word_t    byte_word,
  output logic                 char_valid,
  input  logic                 char_stall,
  output b85_pkg::out_word_t   char_word
);

  logic [23:0]           group_bytes;
  logic [1:0]            held_count;
  logic                  accept;
  logic                  emit;
  logic [31:0]           value;
  b85_pkg::grp_t         grp;
  logic                  grp_free;
  logic                  dig_valid;
  b85_pkg::dig_t         dig;
  logic                  move;
  logic                  busy;
  logic [2:0]            idx;
  logic [2:0]            cnt;
  logic                  send_end;
  logic [4:0][6:0]       chars;
  logic                  out_free;
  logic                  last_char;
  logic                  take;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = !grp_free;
  assign emit       = (held_count == 2'd3) || byte_word.last_byte;
  assign value      = {group_bytes, byte_word.data_byte};

  always_comb begin
    case (held_count)
      2'd0:    grp.value = {value[7:0], 24'd0};
      2'd1:    grp.value = {value[15:0], 16'd0};
      2'd2:    grp.value = {value[23:0], 8'd0};
      default: grp.value = value;
    endcase
    grp.meta.count      = {1'b0, held_count} + 3'd2;
    grp.meta.stream_end = byte_word.last_byte;
  end

  b85_digit_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (accept && emit),
    .grp       (grp),
    .move      (move),
    .grp_free  (grp_free),
    .dig_valid (dig_valid),
    .dig       (dig)
  );

  assign out_free  = !char_valid || !char_stall;
  assign last_char = (idx == (cnt - 3'd1));
  assign take      = dig_valid && (!busy || (out_free && last_char));
  assign move      = !dig_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes <= '0;
      held_count  <= '0;
      busy        <= 1'b0;
      char_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (emit) begin
          group_bytes <= '0;
          held_count  <= '0;
        end else begin
          group_bytes <= {group_bytes[15:0], byte_word.data_byte};
          held_count  <= held_count + 2'd1;
        end
      end
      if (out_free) begin
        char_valid <= busy;
      end
      if (take) begin
        busy <= 1'b1;
      end else if (busy && out_free && last_char) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && busy) begin
      char_word.out_char   <= chars[idx];
      char_word.group_end  <= last_char;
      char_word.stream_end <= last_char && send_end;
    end
    if (take) begin
      idx      <= '0;
      cnt      <= dig.meta.count;
      send_end <= dig.meta.stream_end;
      chars    <= dig.chars;
    end else if (busy && out_free) begin
      idx <= idx + 3'd1;
    end
  end

  `B85_ASSERT_NEXT(a_flush_clears, clk, rst, accept && byte_word.last_byte, held_count == 2'd0)
  `B85_ASSERT_IMPL(a_idx_range, clk, rst, busy, idx < cnt)
  `B85_ASSERT_IMPL(a_take_after_last, clk, rst, take && busy, out_free && last_char)
  `B85_ASSERT_NEXT(a_digits_held, clk, rst, dig_valid && !take, dig_valid)

endmodule
